// ===== hw/rtl/pgca_pkg.sv =====
`default_nettype none

package pgca_pkg;

    localparam int MAX_SECTORS_DEF  = 1024;
    localparam int MAX_ROWS_DEF     = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int ROW_IDX_W   = 11;
    localparam int SEC_IDX_W   = 10;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam int ROW_COUNT_RST    = 128;
    localparam int SECTOR_COUNT_RST = 256;
    localparam logic SKIP_GHOST_RST  = 1'b1;
    localparam logic SCALAR_GRID_RST = 1'b1;

    // result slots of one sample, in output order
    localparam int NRES            = 4;
    localparam int SLOT_W          = $clog2(NRES);
    localparam int SLOT_CORNER     = 0;
    localparam int SLOT_WRAP       = 1;
    localparam int SLOT_OUTER      = 2;
    localparam int SLOT_OUTER_WRAP = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_COUNT    = 2'd0,
        CFG_SECTOR_COUNT = 2'd1,
        CFG_SKIP_GHOST   = 2'd2,
        CFG_SCALAR_GRID  = 2'd3
    } pgca_cfg_idx_t;

    typedef struct packed {
        logic                 sec_zero;
        logic                 end_row;
        logic                 last_row;
        logic                 row_zero;
        logic                 scalar;
        logic [ROW_IDX_W-1:0] row_idx;
        logic [ROW_IDX_W-1:0] outer_row;
        logic [SEC_IDX_W-1:0] sec_idx;
    } pgca_item_ctl_t;

    typedef struct packed {
        logic [NRES-1:0]                mask;
        logic [NRES-1:0][ROW_IDX_W-1:0] row;
        logic [NRES-1:0][SEC_IDX_W-1:0] sec;
        logic                           frame_end;
    } pgca_res_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pgca_sample_if.sv =====
`default_nettype none

interface pgca_sample_if
    import pgca_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] cell_sample;

    modport source (output valid, output cell_sample, input ready);
    modport sink (input valid, input cell_sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pgca_corner_if.sv =====
`default_nettype none

interface pgca_corner_if
    import pgca_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] corner_value;
    logic [ROW_IDX_W-1:0]           row_index;
    logic [SEC_IDX_W-1:0]           sector_index;
    logic                           run_last;
    logic                           frame_last;

    modport source (
        output valid, output corner_value, output row_index, output sector_index,
        output run_last, output frame_last, input ready
    );
    modport sink (
        input valid, input corner_value, input row_index, input sector_index,
        input run_last, input frame_last, output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/pgca_ram.sv =====
`default_nettype none

module pgca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pgca_corner.sv =====
`default_nettype none

module pgca_corner
    import pgca_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] left,
    input  wire logic signed [SAMPLE_WIDTH-1:0] first,
    input  wire logic signed [SAMPLE_WIDTH-1:0] up,
    input  wire logic signed [SAMPLE_WIDTH-1:0] upleft,
    input  wire logic signed [SAMPLE_WIDTH-1:0] upfirst,
    input  wire pgca_item_ctl_t                 ctl,
    output logic signed [SAMPLE_WIDTH-1:0]      value [NRES],
    output pgca_res_ctl_t                       res
);

    localparam int W = SAMPLE_WIDTH;

    // floor means: exact sum, arithmetic shift
    function automatic logic signed [W-1:0] mean2(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b
    );
        logic signed [W:0] sum;
        sum = {a[W-1], a} + {b[W-1], b};
        return sum[W:1];
    endfunction

    function automatic logic signed [W-1:0] mean4(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b,
        input logic signed [W-1:0] c,
        input logic signed [W-1:0] d
    );
        logic signed [W+1:0] sum;
        sum = {{2{a[W-1]}}, a} + {{2{b[W-1]}}, b} + {{2{c[W-1]}}, c}
            + {{2{d[W-1]}}, d};
        return sum[W+1:2];
    endfunction

    logic signed [W-1:0] cur0;
    logic signed [W-1:0] prev0;

    assign cur0  = ctl.sec_zero ? sample : first;
    assign prev0 = ctl.sec_zero ? up : upfirst;

    always_comb
    begin
        if (ctl.scalar)
        begin
            value[SLOT_CORNER] = ctl.row_zero ? mean2(sample, left)
                                              : mean4(sample, left, up, upleft);
            value[SLOT_WRAP]   = ctl.row_zero ? mean2(cur0, sample)
                                              : mean4(cur0, sample, prev0, up);
        end
        else
        begin
            value[SLOT_CORNER] = sample;
            value[SLOT_WRAP]   = sample;
        end
        value[SLOT_OUTER]      = mean2(sample, left);
        value[SLOT_OUTER_WRAP] = mean2(cur0, sample);
    end

    always_comb
    begin
        res.mask = '0;
        if (ctl.scalar)
        begin
            res.mask[SLOT_CORNER]     = !ctl.sec_zero;
            res.mask[SLOT_WRAP]       = ctl.end_row;
            res.mask[SLOT_OUTER]      = ctl.last_row && !ctl.sec_zero;
            res.mask[SLOT_OUTER_WRAP] = ctl.last_row && ctl.end_row;
        end
        else
        begin
            res.mask[SLOT_CORNER] = 1'b1;
        end
        res.row[SLOT_CORNER]     = ctl.row_idx;
        res.row[SLOT_WRAP]       = ctl.row_idx;
        res.row[SLOT_OUTER]      = ctl.outer_row;
        res.row[SLOT_OUTER_WRAP] = ctl.outer_row;
        res.sec[SLOT_CORNER]     = ctl.sec_idx;
        res.sec[SLOT_WRAP]       = '0;
        res.sec[SLOT_OUTER]      = ctl.sec_idx;
        res.sec[SLOT_OUTER_WRAP] = '0;
        res.frame_end            = ctl.end_row && ctl.last_row;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/polar_grid_corner_average_unit.sv =====
`default_nettype none

// Polar grid corner averaging.
// samples: one cell_sample per beat, row by row, sector by sector.
// corners: one corner_value per beat with row_index and sector_index;
//   run_last closes the beats caused by one sample, frame_last the grid.
// cfg_we/cfg_index/cfg_wdata: row_count, sector_count, skip_ghost_row,
//   scalar_grid; any write restarts the frame. Write only while idle.
// A sample with results waits in the work stage until the output stage is free.
// Throughput: the result port moves one beat per cycle while corners.ready
//   is high. With scalar_grid a sample yields one result in inner rows, two
//   at their end, two in the last row and four at the end of the last row;
//   sector 0 yields none unless it ends the row, then one (two in the last
//   row). Without scalar_grid each sample yields one. Ghost-row samples are
//   dropped on entry, one per cycle while samples.ready is high.
// The previous row lives in one row memory (read at entry, written back on
//   leaving the work stage, forwarded when a single sector hits the same entry).
// Reset: registers return to 128 rows, 256 sectors, ghost row skipped,
//   scalar mode; the row memory is not cleared and needs no clearing pass.
// Stall: the output stage holds its beats, the next sample with results waits
//   in the work stage, then samples.ready drops until the last beat is taken.
module polar_grid_corner_average_unit
    import pgca_pkg::*;
#(
    parameter int MAX_SECTORS  = MAX_SECTORS_DEF,
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    pgca_sample_if.sink                 samples,
    pgca_corner_if.source               corners
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int SPOS_W = $clog2(MAX_SECTORS);
    localparam int SCNT_W = $clog2(MAX_SECTORS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int ROWS_RST = (ROW_COUNT_RST > MAX_ROWS) ? MAX_ROWS : ROW_COUNT_RST;
    localparam int SECS_RST = (SECTOR_COUNT_RST > MAX_SECTORS) ? MAX_SECTORS
                                                               : SECTOR_COUNT_RST;

    // configuration and frame position
    logic [RCNT_W-1:0] eff_rows_reg, eff_rows_next;
    logic [SCNT_W-1:0] eff_sec_reg, eff_sec_next;
    logic              skip_reg, skip_next;
    logic              scalar_reg, scalar_next;
    logic [RCNT_W-1:0] row_pos_reg, row_pos_next;
    logic [SPOS_W-1:0] sec_pos_reg, sec_pos_next;
    logic              ghost_reg, ghost_next;

    logic [RCNT_W-1:0] cfg_rows_eff;
    logic [SCNT_W-1:0] cfg_sec_eff;
    logic              accept;
    logic              sec_end;
    logic              row_top;
    logic              load_s1;

    // work stage
    logic              s1_valid_reg, s1_valid_next;
    logic [W-1:0]      s1_sample_reg;
    logic [SPOS_W-1:0] s1_sec_reg;
    logic [RCNT_W-1:0] s1_row_reg;
    logic              s1_end_reg;
    logic              s1_last_reg;
    logic              s1_scalar_reg;
    logic              s1_fwd_reg;
    logic [W-1:0]      fwd_data_reg;
    logic              s1_adv;
    logic              fwd_hit;

    // row neighbors
    logic [W-1:0] left_reg;
    logic [W-1:0] upleft_reg;
    logic [W-1:0] first_reg;
    logic [W-1:0] upfirst_reg;
    logic [W-1:0] ram_rdata;
    logic [W-1:0] up;

    pgca_item_ctl_t      item_ctl;
    pgca_res_ctl_t       res;
    logic signed [W-1:0] res_val [NRES];

    // output stage
    logic signed [W-1:0]            s2_val_reg [NRES];
    logic [NRES-1:0][ROW_IDX_W-1:0] s2_row_reg;
    logic [NRES-1:0][SEC_IDX_W-1:0] s2_sec_reg;
    logic                           s2_frame_reg;
    logic [NRES-1:0]                s2_mask_reg, s2_mask_next;
    logic [SLOT_W-1:0]              pick;
    logic [NRES-1:0]                pick_oh;
    logic                           out_last;
    logic                           out_take;
    logic                           s2_free;
    logic                           load_s2;

    // register write decode
    always_comb
    begin
        if (cfg_wdata == '0)
            cfg_rows_eff = RCNT_W'(1);
        else if (int'(cfg_wdata) > MAX_ROWS)
            cfg_rows_eff = RCNT_W'(MAX_ROWS);
        else
            cfg_rows_eff = RCNT_W'(cfg_wdata);

        if (cfg_wdata == '0)
            cfg_sec_eff = SCNT_W'(1);
        else if (int'(cfg_wdata) > MAX_SECTORS)
            cfg_sec_eff = SCNT_W'(MAX_SECTORS);
        else
            cfg_sec_eff = SCNT_W'(cfg_wdata);
    end

    assign accept  = samples.valid && samples.ready;
    assign sec_end = (sec_pos_reg == SPOS_W'(eff_sec_reg - 1'b1));
    assign row_top = scalar_reg ? (row_pos_reg == eff_rows_reg - 1'b1)
                                : (row_pos_reg == eff_rows_reg);
    assign load_s1 = accept && !ghost_reg;

    always_comb
    begin
        eff_rows_next = eff_rows_reg;
        eff_sec_next  = eff_sec_reg;
        skip_next     = skip_reg;
        scalar_next   = scalar_reg;
        row_pos_next  = row_pos_reg;
        sec_pos_next  = sec_pos_reg;
        ghost_next    = ghost_reg;
        if (cfg_we)
        begin
            case (pgca_cfg_idx_t'(cfg_index))
                CFG_ROW_COUNT:    eff_rows_next = cfg_rows_eff;
                CFG_SECTOR_COUNT: eff_sec_next  = cfg_sec_eff;
                CFG_SKIP_GHOST:   skip_next     = cfg_wdata[0];
                CFG_SCALAR_GRID:  scalar_next   = cfg_wdata[0];
                default:          eff_rows_next = eff_rows_reg;
            endcase
            row_pos_next = '0;
            sec_pos_next = '0;
            ghost_next   = (pgca_cfg_idx_t'(cfg_index) == CFG_SKIP_GHOST) ? cfg_wdata[0]
                                                                          : skip_reg;
        end
        else if (accept)
        begin
            if (!sec_end)
            begin
                sec_pos_next = sec_pos_reg + 1'b1;
            end
            else
            begin
                sec_pos_next = '0;
                if (ghost_reg)
                begin
                    ghost_next = 1'b0;
                end
                else if (row_top)
                begin
                    row_pos_next = '0;
                    ghost_next   = skip_reg;
                end
                else
                begin
                    row_pos_next = row_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_rows_reg <= RCNT_W'(ROWS_RST);
            eff_sec_reg  <= SCNT_W'(SECS_RST);
            skip_reg     <= SKIP_GHOST_RST;
            scalar_reg   <= SCALAR_GRID_RST;
            row_pos_reg  <= '0;
            sec_pos_reg  <= '0;
            ghost_reg    <= SKIP_GHOST_RST;
        end
        else
        begin
            eff_rows_reg <= eff_rows_next;
            eff_sec_reg  <= eff_sec_next;
            skip_reg     <= skip_next;
            scalar_reg   <= scalar_next;
            row_pos_reg  <= row_pos_next;
            sec_pos_reg  <= sec_pos_next;
            ghost_reg    <= ghost_next;
        end
    end

    // row memory: read at entry, written back as the sample leaves the work stage
    pgca_ram #(
        .WIDTH(W),
        .DEPTH(MAX_SECTORS)
    ) u_row_ram (
        .clk  (clk),
        .we   (s1_adv && s1_scalar_reg),
        .waddr(s1_sec_reg),
        .wdata(s1_sample_reg),
        .re   (load_s1),
        .raddr(sec_pos_reg),
        .rdata(ram_rdata)
    );

    // same entry written and read at one edge
    assign fwd_hit = s1_valid_reg && s1_adv && s1_scalar_reg && (s1_sec_reg == sec_pos_reg);
    assign up      = s1_fwd_reg ? fwd_data_reg : ram_rdata;

    assign s2_free       = (s2_mask_reg == '0) || (corners.ready && out_last);
    assign s1_adv        = s1_valid_reg && ((res.mask == '0) || s2_free);
    assign samples.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load_s1)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_sample_reg <= samples.cell_sample;
            s1_sec_reg    <= sec_pos_reg;
            s1_row_reg    <= row_pos_reg;
            s1_end_reg    <= sec_end;
            s1_last_reg   <= row_top;
            s1_scalar_reg <= scalar_reg;
            s1_fwd_reg    <= fwd_hit;
            fwd_data_reg  <= s1_sample_reg;
        end
        if (s1_adv && s1_scalar_reg)
        begin
            left_reg   <= s1_sample_reg;
            upleft_reg <= up;
            if (s1_sec_reg == '0)
            begin
                first_reg   <= s1_sample_reg;
                upfirst_reg <= up;
            end
        end
    end

    always_comb
    begin
        item_ctl.sec_zero  = (s1_sec_reg == '0);
        item_ctl.end_row   = s1_end_reg;
        item_ctl.last_row  = s1_last_reg;
        item_ctl.row_zero  = (s1_row_reg == '0);
        item_ctl.scalar    = s1_scalar_reg;
        item_ctl.row_idx   = ROW_IDX_W'(s1_row_reg);
        item_ctl.outer_row = ROW_IDX_W'(eff_rows_reg);
        item_ctl.sec_idx   = SEC_IDX_W'(s1_sec_reg);
    end

    pgca_corner #(
        .SAMPLE_WIDTH(W)
    ) u_corner (
        .sample (s1_sample_reg),
        .left   (left_reg),
        .first  (first_reg),
        .up     (up),
        .upleft (upleft_reg),
        .upfirst(upfirst_reg),
        .ctl    (item_ctl),
        .value  (res_val),
        .res    (res)
    );

    // output stage, lowest pending slot first
    always_comb
    begin
        pick = '0;
        for (int i = NRES - 1; i >= 0; i--)
        begin
            if (s2_mask_reg[i])
                pick = SLOT_W'(i);
        end
    end

    assign pick_oh  = NRES'(1) << pick;
    assign out_last = ((s2_mask_reg & ~pick_oh) == '0);
    assign out_take = corners.valid && corners.ready;
    assign load_s2  = s1_adv && (res.mask != '0);

    always_comb
    begin
        s2_mask_next = s2_mask_reg;
        if (load_s2)
            s2_mask_next = res.mask;
        else if (out_take)
            s2_mask_next = s2_mask_reg & ~pick_oh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_mask_reg <= '0;
        end
        else
        begin
            s2_mask_reg <= s2_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s2)
        begin
            s2_val_reg   <= res_val;
            s2_row_reg   <= res.row;
            s2_sec_reg   <= res.sec;
            s2_frame_reg <= res.frame_end;
        end
    end

    assign corners.valid        = (s2_mask_reg != '0);
    assign corners.corner_value = s2_val_reg[pick];
    assign corners.row_index    = s2_row_reg[pick];
    assign corners.sector_index = s2_sec_reg[pick];
    assign corners.run_last     = out_last;
    assign corners.frame_last   = out_last && s2_frame_reg;

    // forwarding only arises when a row has a single sector
    a_fwd_single_sector: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> (eff_sec_reg == SCNT_W'(1)))
        else $error("row memory forward with more than one sector");

    a_sector_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> (SCNT_W'(sec_pos_reg) < eff_sec_reg))
        else $error("sector position beyond sector count");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> (row_pos_reg <= eff_rows_reg))
        else $error("row position beyond row count");

    a_frame_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (corners.valid && corners.frame_last) |-> (s2_mask_reg == pick_oh))
        else $error("frame end flagged before the last beat of a sample");

endmodule

`default_nettype wire
